// File: rtl/core/kwdt_pkg.sv
// Package for the keyed watchdog timer: transaction structs, command and
// register offset codes, key values and configuration word bit positions.
// No dependencies.
`default_nettype none

package kwdt_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [3:0] reg_idx_t;

    localparam cmd_t CMD_TICK  = 2'd0;
    localparam cmd_t CMD_WRITE = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;

    localparam reg_idx_t REG_CFG     = 4'd0;
    localparam reg_idx_t REG_COUNT   = 4'd2;
    localparam reg_idx_t REG_SCALED  = 4'd4;
    localparam reg_idx_t REG_FEED    = 4'd6;
    localparam reg_idx_t REG_KEY     = 4'd7;
    localparam reg_idx_t REG_COMPARE = 4'd8;

    localparam logic [31:0] KEY_VALUE  = 32'h0051_f15e;
    localparam logic [31:0] FEED_VALUE = 32'h0d09_f00d;

    localparam int SCALE_WIDTH      = 4;
    localparam int CFG_RST_EN_BIT   = 8;
    localparam int CFG_ZERO_CMP_BIT = 9;
    localparam int CFG_ALWAYS_BIT   = 12;
    localparam int CFG_AWAKE_BIT    = 13;
    localparam int CFG_PENDING_BIT  = 28;

    typedef logic [SCALE_WIDTH-1:0] scale_t;

    typedef struct packed {
        cmd_t        command;
        reg_idx_t    reg_index;
        logic [31:0] write_data;
        logic        core_awake;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        interrupt_pending;
        logic        reset_request;
        logic        write_ignored;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/keyed_watchdog_timer.sv
// Keyed watchdog timer top level: input register, watchdog core, result register.
// Throughput: one transaction per cycle; the input register and result register
// each advance whenever the next stage can take their contents.
// Reset (aresetn, synchronous, active low): both stages empty, counter and
// configuration zero, compare value all ones, unlock disarmed. Uses kwdt_core.
`default_nettype none

module keyed_watchdog_timer import kwdt_pkg::*; #(
    parameter int COUNT_WIDTH = 31,
    parameter int CMP_WIDTH   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [3:0]  s_reg_index,
    input  wire logic [31:0] s_write_data,
    input  wire logic        s_core_awake,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_read_data,
    output logic             m_interrupt_pending,
    output logic             m_reset_request,
    output logic             m_write_ignored
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command    <= s_command;
            in_item_reg.reg_index  <= s_reg_index;
            in_item_reg.write_data <= s_write_data;
            in_item_reg.core_awake <= s_core_awake;
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    kwdt_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .CMP_WIDTH   (CMP_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (in_item_reg),
        .result  (core_res)
    );

    assign m_valid             = out_valid_reg;
    assign m_read_data         = out_res_reg.read_data;
    assign m_interrupt_pending = out_res_reg.interrupt_pending;
    assign m_reset_request     = out_res_reg.reset_request;
    assign m_write_ignored     = out_res_reg.write_ignored;

endmodule

`default_nettype wire

// File: rtl/core/kwdt_core.sv
// Watchdog state registers and the single-pass update for one transaction.
// Depends on kwdt_pkg.
`default_nettype none

module kwdt_core import kwdt_pkg::*; #(
    parameter int COUNT_WIDTH = 31,
    parameter int CMP_WIDTH   = 16
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire item_t   item,
    output result_t      result
);

    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next, cnt_inc;
    scale_t                 scale_reg, scale_next;
    logic                   rst_en_reg, rst_en_next;
    logic                   zero_cmp_reg, zero_cmp_next;
    logic                   always_reg, always_next;
    logic                   awake_reg, awake_next;
    logic                   pending_reg, pending_next;
    logic [CMP_WIDTH-1:0]   cmp_reg, cmp_next;
    logic                   armed_reg, armed_next;
    logic [CMP_WIDTH-1:0]   scaled_cur, scaled_inc;
    logic [31:0]            cfg_word;

    always_comb begin
        cfg_word                   = '0;
        cfg_word[SCALE_WIDTH-1:0]  = scale_reg;
        cfg_word[CFG_RST_EN_BIT]   = rst_en_reg;
        cfg_word[CFG_ZERO_CMP_BIT] = zero_cmp_reg;
        cfg_word[CFG_ALWAYS_BIT]   = always_reg;
        cfg_word[CFG_AWAKE_BIT]    = awake_reg;
        cfg_word[CFG_PENDING_BIT]  = pending_reg;
    end

    assign scaled_cur = CMP_WIDTH'(cnt_reg >> scale_reg);
    assign cnt_inc    = (always_reg || (awake_reg && item.core_awake))
                        ? cnt_reg + COUNT_WIDTH'(1) : cnt_reg;
    assign scaled_inc = CMP_WIDTH'(cnt_inc >> scale_reg);

    always_comb begin
        cnt_next      = cnt_reg;
        scale_next    = scale_reg;
        rst_en_next   = rst_en_reg;
        zero_cmp_next = zero_cmp_reg;
        always_next   = always_reg;
        awake_next    = awake_reg;
        pending_next  = pending_reg;
        cmp_next      = cmp_reg;
        armed_next    = armed_reg;
        result        = '0;

        unique case (item.command)
            CMD_TICK: begin
                cnt_next = cnt_inc;
                if (scaled_inc >= cmp_reg) begin
                    pending_next = 1'b1;
                    if (zero_cmp_reg) begin
                        cnt_next = '0;
                    end
                    result.reset_request = rst_en_reg;
                end
            end
            CMD_WRITE: begin
                if (item.reg_index == REG_KEY && item.write_data == KEY_VALUE) begin
                    armed_next = 1'b1;
                end else if (!armed_reg) begin
                    result.write_ignored = 1'b1;
                end else begin
                    armed_next = 1'b0;
                    unique case (item.reg_index)
                        REG_CFG: begin
                            scale_next    = item.write_data[SCALE_WIDTH-1:0];
                            rst_en_next   = item.write_data[CFG_RST_EN_BIT];
                            zero_cmp_next = item.write_data[CFG_ZERO_CMP_BIT];
                            always_next   = item.write_data[CFG_ALWAYS_BIT];
                            awake_next    = item.write_data[CFG_AWAKE_BIT];
                            pending_next  = item.write_data[CFG_PENDING_BIT];
                        end
                        REG_COUNT: begin
                            cnt_next = item.write_data[COUNT_WIDTH-1:0];
                        end
                        REG_FEED: begin
                            if (item.write_data == FEED_VALUE) begin
                                cnt_next = '0;
                            end
                        end
                        REG_COMPARE: begin
                            cmp_next = item.write_data[CMP_WIDTH-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CMD_READ: begin
                unique case (item.reg_index)
                    REG_CFG:     result.read_data = cfg_word;
                    REG_COUNT:   result.read_data = 32'(cnt_reg);
                    REG_SCALED:  result.read_data = 32'(scaled_cur);
                    REG_KEY:     result.read_data = 32'(armed_reg);
                    REG_COMPARE: result.read_data = 32'(cmp_reg);
                    default:     result.read_data = '0;
                endcase
            end
            default: begin
            end
        endcase

        result.interrupt_pending = pending_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            scale_reg    <= '0;
            rst_en_reg   <= 1'b0;
            zero_cmp_reg <= 1'b0;
            always_reg   <= 1'b0;
            awake_reg    <= 1'b0;
            pending_reg  <= 1'b0;
            cmp_reg      <= '1;
            armed_reg    <= 1'b0;
        end else if (en) begin
            cnt_reg      <= cnt_next;
            scale_reg    <= scale_next;
            rst_en_reg   <= rst_en_next;
            zero_cmp_reg <= zero_cmp_next;
            always_reg   <= always_next;
            awake_reg    <= awake_next;
            pending_reg  <= pending_next;
            cmp_reg      <= cmp_next;
            armed_reg    <= armed_next;
        end
    end

endmodule

`default_nettype wire
